FILE: rtl/core/quadratic_root_solver_macros.svh
// Assertion macros shared by the checker of the quadratic root solver.
// Depends on nothing; included by files that assert.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define QRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`endif

FILE: rtl/core/qrs_pkg.sv
// Types and constants of the quadratic root solver.
// Depends on nothing; imported by the top level and the checker.
package qrs_pkg;

	// Classification of the roots.
	typedef enum logic [1:0] {
		KIND_INVALID  = 2'd0,
		KIND_DISTINCT = 2'd1,
		KIND_EQUAL    = 2'd2,
		KIND_COMPLEX  = 2'd3
	} kind_t;

	// Output value range.
	localparam int VALUE_W = 32;
	localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

endpackage

FILE: rtl/core/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cycle while enabled.
// Depends on nothing; instantiated by quadratic_root_solver.
module qrs_sqrt_cell #(
	parameter int RW = 8,
	parameter int XW = 16,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [RW-1:0]     root_in,
	input  logic [RW+1:0]     rem_in,
	input  logic [XW-1:0]     rad_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [RW-1:0]     root_out,
	output logic [RW+1:0]     rem_out,
	output logic [XW-1:0]     rad_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fits;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_in[RW-1:0], rad_in[XW-1:XW-2]};
		trial  = {root_in, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= fits ? (rem_sh - trial) : rem_sh;
			root_out <= {root_in[RW-2:0], fits};
			rad_out  <= {rad_in[XW-3:0], 2'b00};
			side_out <= side_in;
		end
	end

endmodule

FILE: rtl/core/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit for each of two lanes.
// Depends on nothing; instantiated by quadratic_root_solver.
module qrs_div_cell #(
	parameter int NW = 8,
	parameter int DW = 4,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [NW-1:0]     num0_in,
	input  logic [NW-1:0]     num1_in,
	input  logic [DW-1:0]     rem0_in,
	input  logic [DW-1:0]     rem1_in,
	input  logic [DW-1:0]     dvs_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              vld_out,
	output logic [NW-1:0]     num0_out,
	output logic [NW-1:0]     num1_out,
	output logic [DW-1:0]     rem0_out,
	output logic [DW-1:0]     rem1_out,
	output logic [DW-1:0]     dvs_out,
	output logic [SIDE_W-1:0] side_out
);

	logic [DW:0] t0, t1, dx;
	logic        ge0, ge1;

	// Shift in the next numerator bit and subtract the divisor where it fits.
	always_comb begin
		dx  = {1'b0, dvs_in};
		t0  = {rem0_in, num0_in[NW-1]};
		t1  = {rem1_in, num1_in[NW-1]};
		ge0 = (t0 >= dx);
		ge1 = (t1 >= dx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem0_out <= ge0 ? DW'(t0 - dx) : t0[DW-1:0];
			rem1_out <= ge1 ? DW'(t1 - dx) : t1[DW-1:0];
			num0_out <= {num0_in[NW-2:0], ge0};
			num1_out <= {num1_in[NW-2:0], ge1};
			dvs_out  <= dvs_in;
			side_out <= side_in;
		end
	end

endmodule

FILE: rtl/core/quadratic_root_solver.sv
// Top level of the quadratic root solver: products, square root chain, divider chain.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
//
// Takes one word of coefficients a, b, c per cycle unless the output stalls, and returns
// the class of the roots and two fixed-point values with FRAC_BITS fraction bits,
// truncated and saturated. Words pass the product and discriminant stages, the square
// root chain (one root bit per cell), the numerator stage, the divider chain (one
// quotient bit per cell) and the output register. The whole pipeline holds while a
// result waits at the output, and moves on as soon as it is taken.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int COEFF_WIDTH = 16,
	parameter int FRAC_BITS = 16,
	localparam int S_DATA_W = ((3 * COEFF_WIDTH + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// coef_a, coef_b, coef_c from the lowest bit up, zero padding above
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// root_kind, first_value, second_value from the lowest bit up, zero padding above
	output logic [71:0]         m_tdata
);

	localparam int CW = COEFF_WIDTH;
	localparam int PW = 2 * CW;
	localparam int DMW = PW + 1;
	localparam int NBW = CW + FRAC_BITS + 1;
	localparam int SW = CW + FRAC_BITS + 1;
	localparam int XW = 2 * SW;
	localparam int NW = CW + FRAC_BITS + 2;
	localparam int DW = CW + 1;
	localparam int SQ_SIDE_W = 2 + CW + NBW;
	localparam int DV_SIDE_W = 4;

	logic adv;

	logic signed [CW-1:0] in_a, in_b, in_c;
	logic [CW-1:0]        mag_a, mag_b, mag_c;

	logic                 vld_s1;
	logic signed [CW-1:0] a_s1, b_s1;
	logic [PW-1:0]        bb_s1, ac_s1;
	logic                 acpos_s1;

	logic                 vld_s2;
	logic [DMW-1:0]       dm_s2;
	logic                 dneg_s2;
	logic signed [CW-1:0] a_s2;
	logic signed [NBW-1:0] nb_s2;

	logic [DMW-1:0] ac4, bbx;
	kind_t          kind_s2;

	// Pipeline moves whenever the output register is free or being emptied.
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Unpack and take magnitudes for the products.
	always_comb begin
		in_a  = s_tdata[CW-1:0];
		in_b  = s_tdata[2*CW-1:CW];
		in_c  = s_tdata[3*CW-1:2*CW];
		mag_a = in_a[CW-1] ? CW'(-in_a) : in_a;
		mag_b = in_b[CW-1] ? CW'(-in_b) : in_b;
		mag_c = in_c[CW-1] ? CW'(-in_c) : in_c;
	end

	// Stage one: b squared and a times c.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1     <= in_a;
			b_s1     <= in_b;
			bb_s1    <= mag_b * mag_b;
			ac_s1    <= mag_a * mag_c;
			acpos_s1 <= (in_c != '0) && (in_a[CW-1] == in_c[CW-1]);
		end
	end

	// Stage two: discriminant magnitude and sign.
	always_comb begin
		ac4 = {ac_s1[PW-2:0], 2'b00};
		ac4 = {ac_s1, 1'b0} << 1;
		bbx = {1'b0, bb_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2  <= a_s1;
			nb_s2 <= -(NBW'(b_s1) <<< FRAC_BITS);
			if (!acpos_s1) begin
				dm_s2   <= bbx + ac4;
				dneg_s2 <= 1'b0;
			end else if (bbx >= ac4) begin
				dm_s2   <= bbx - ac4;
				dneg_s2 <= 1'b0;
			end else begin
				dm_s2   <= ac4 - bbx;
				dneg_s2 <= 1'b1;
			end
		end
	end

	// Classify the roots from the discriminant.
	always_comb begin
		if (a_s2 == '0) begin
			kind_s2 = KIND_INVALID;
		end else if (dm_s2 == '0) begin
			kind_s2 = KIND_EQUAL;
		end else if (dneg_s2) begin
			kind_s2 = KIND_COMPLEX;
		end else begin
			kind_s2 = KIND_DISTINCT;
		end
	end

	// Square root chain over the scaled discriminant.
	logic                 sq_vld  [0:SW];
	logic [SW-1:0]        sq_root [0:SW];
	logic [SW+1:0]        sq_rem  [0:SW];
	logic [XW-1:0]        sq_rad  [0:SW];
	logic [SQ_SIDE_W-1:0] sq_side [0:SW];

	assign sq_vld[0]  = vld_s2;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_rad[0]  = XW'(dm_s2) << (2 * FRAC_BITS);
	assign sq_side[0] = {kind_s2, a_s2, nb_s2};

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		qrs_sqrt_cell #(.RW(SW), .XW(XW), .SIDE_W(SQ_SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sq_vld[i]),
			.root_in  (sq_root[i]),
			.rem_in   (sq_rem[i]),
			.rad_in   (sq_rad[i]),
			.side_in  (sq_side[i]),
			.vld_out  (sq_vld[i+1]),
			.root_out (sq_root[i+1]),
			.rem_out  (sq_rem[i+1]),
			.rad_out  (sq_rad[i+1]),
			.side_out (sq_side[i+1])
		);
	end

	// Stage three: numerators, signs and divisor.
	kind_t                 kind_sq;
	logic signed [CW-1:0]  a_sq;
	logic signed [NBW-1:0] nb_sq;
	logic signed [NW:0]    nbx, sx, num0, num1;
	logic signed [CW:0]    ax;
	logic [CW:0]           amag;

	logic                 vld_s3;
	logic [NW-1:0]        n0_s3, n1_s3;
	logic [DW-1:0]        dvs_s3;
	logic [DV_SIDE_W-1:0] side_s3;

	always_comb begin
		kind_sq = kind_t'(sq_side[SW][SQ_SIDE_W-1 -: 2]);
		a_sq    = sq_side[SW][NBW +: CW];
		nb_sq   = sq_side[SW][NBW-1:0];
		nbx     = (NW+1)'(nb_sq);
		sx      = (NW+1)'(sq_root[SW]);
		num0    = (kind_sq == KIND_DISTINCT) ? (nbx + sx) : nbx;
		if (kind_sq == KIND_DISTINCT) begin
			num1 = nbx - sx;
		end else if (kind_sq == KIND_COMPLEX) begin
			num1 = sx;
		end else begin
			num1 = nbx;
		end
		ax   = (CW+1)'(a_sq);
		amag = ax[CW] ? -ax : ax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n0_s3   <= num0[NW] ? NW'(-num0) : num0[NW-1:0];
			n1_s3   <= num1[NW] ? NW'(-num1) : num1[NW-1:0];
			dvs_s3  <= {amag[CW-1:0], 1'b0};
			side_s3 <= {kind_sq, num0[NW] ^ a_sq[CW-1], num1[NW] ^ a_sq[CW-1]};
		end
	end

	// Divider chain, both quotients side by side.
	logic                 dv_vld  [0:NW];
	logic [NW-1:0]        dv_n0   [0:NW];
	logic [NW-1:0]        dv_n1   [0:NW];
	logic [DW-1:0]        dv_r0   [0:NW];
	logic [DW-1:0]        dv_r1   [0:NW];
	logic [DW-1:0]        dv_d    [0:NW];
	logic [DV_SIDE_W-1:0] dv_side [0:NW];

	assign dv_vld[0]  = vld_s3;
	assign dv_n0[0]   = n0_s3;
	assign dv_n1[0]   = n1_s3;
	assign dv_r0[0]   = '0;
	assign dv_r1[0]   = '0;
	assign dv_d[0]    = dvs_s3;
	assign dv_side[0] = side_s3;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(.NW(NW), .DW(DW), .SIDE_W(DV_SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (dv_vld[j]),
			.num0_in  (dv_n0[j]),
			.num1_in  (dv_n1[j]),
			.rem0_in  (dv_r0[j]),
			.rem1_in  (dv_r1[j]),
			.dvs_in   (dv_d[j]),
			.side_in  (dv_side[j]),
			.vld_out  (dv_vld[j+1]),
			.num0_out (dv_n0[j+1]),
			.num1_out (dv_n1[j+1]),
			.rem0_out (dv_r0[j+1]),
			.rem1_out (dv_r1[j+1]),
			.dvs_out  (dv_d[j+1]),
			.side_out (dv_side[j+1])
		);
	end

	// Final stage: sign, saturation and the output register.
	kind_t              kind_dv;
	logic [63:0]        q0, q1;
	logic [VALUE_W-1:0] v0, v1;
	logic               vld_q;
	kind_t              kind_q;
	logic [VALUE_W-1:0] first_q, second_q;

	always_comb begin
		kind_dv = kind_t'(dv_side[NW][3:2]);
		q0 = 64'(dv_n0[NW]);
		q1 = 64'(dv_n1[NW]);
		if (dv_side[NW][1]) begin
			v0 = (q0 > NEG_LIMIT) ? NEG_LIMIT[VALUE_W-1:0] : VALUE_W'(-q0);
		end else begin
			v0 = (q0 > POS_LIMIT) ? POS_LIMIT[VALUE_W-1:0] : q0[VALUE_W-1:0];
		end
		if (dv_side[NW][0]) begin
			v1 = (q1 > NEG_LIMIT) ? NEG_LIMIT[VALUE_W-1:0] : VALUE_W'(-q1);
		end else begin
			v1 = (q1 > POS_LIMIT) ? POS_LIMIT[VALUE_W-1:0] : q1[VALUE_W-1:0];
		end
		if (kind_dv == KIND_INVALID) begin
			v0 = '0;
			v1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_q   <= kind_dv;
			first_q  <= v0;
			second_q <= v1;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {6'b0, second_q, first_q, kind_q};

endmodule

FILE: rtl/core/qrs_checker.sv
// Port-level checker for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and quadratic_root_solver_macros.svh.
`include "quadratic_root_solver_macros.svh"

module qrs_checker
	import qrs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	kind_t out_kind;

	// Class field of the offered output word.
	assign out_kind = kind_t'(m_tdata[1:0]);

	// A word that waits at the output stays offered.
	`QRS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped while stalled")

	// With the output empty the pipeline must take input.
	`QRS_ASSERT(a_ready_free, !m_tvalid |-> s_tready, "input blocked with empty output")

	// An invalid coefficient set gives zero values.
	`QRS_ASSERT(a_invalid_zero, m_tvalid && out_kind == KIND_INVALID |-> m_tdata[65:2] == '0, "invalid kind, values")

	// A repeated root appears twice.
	`QRS_ASSERT(a_equal_same, m_tvalid && out_kind == KIND_EQUAL |-> m_tdata[33:2] == m_tdata[65:34], "roots differ")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
